### design/usvg_pkg.sv
// shared types, constants and arithmetic helpers of the uv sphere vertex generator
package usvg_pkg;

   localparam int QUO_BITS    = 17;
   localparam int COUNT_BITS  = 10;
   localparam int POST_STAGES = 4;
   localparam int CSR_BITS    = 3;
   localparam int ATAN_ENTRIES = 24;

   localparam logic [CSR_BITS-1:0] CSR_CENTER_X    = 3'd0;
   localparam logic [CSR_BITS-1:0] CSR_CENTER_Y    = 3'd1;
   localparam logic [CSR_BITS-1:0] CSR_CENTER_Z    = 3'd2;
   localparam logic [CSR_BITS-1:0] CSR_RADIUS      = 3'd3;
   localparam logic [CSR_BITS-1:0] CSR_RING_COUNT  = 3'd4;
   localparam logic [CSR_BITS-1:0] CSR_SLICE_COUNT = 3'd5;

   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [15:0] ONE_Q14   = 16'sd16384;

   typedef struct packed {
      logic              flip;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } cordic_type;

   function automatic logic signed [33:0] atan_turns(input int stage);
      logic signed [33:0] a;
      case (stage)
         0:  a = 34'sd536870912;
         1:  a = 34'sd316933406;
         2:  a = 34'sd167458907;
         3:  a = 34'sd85004756;
         4:  a = 34'sd42667331;
         5:  a = 34'sd21354465;
         6:  a = 34'sd10679838;
         7:  a = 34'sd5340245;
         8:  a = 34'sd2670163;
         9:  a = 34'sd1335086;
         10: a = 34'sd667544;
         11: a = 34'sd333772;
         12: a = 34'sd166886;
         13: a = 34'sd83443;
         14: a = 34'sd41722;
         15: a = 34'sd20861;
         16: a = 34'sd10430;
         17: a = 34'sd5215;
         18: a = 34'sd2608;
         19: a = 34'sd1304;
         20: a = 34'sd652;
         21: a = 34'sd326;
         22: a = 34'sd163;
         23: a = 34'sd81;
         default: a = 34'sd0;
      endcase
      return a;
   endfunction

   function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
      logic signed [33:0] s;
      s = (v + 34'sd32768) >>> 16;
      if (s > 34'sd16384) begin
         return ONE_Q14;
      end else if (s < -34'sd16384) begin
         return -ONE_Q14;
      end else begin
         return s[15:0];
      end
   endfunction

endpackage

### design/uv_sphere_vertex_generator_unit.sv
// top level of the uv sphere vertex generator
// usage:
//   req channel: one grid point (ring, slice) per transaction, taken when
//   req_valid is high and req_stall is low
//   rsp channel: one vertex per transaction (position, normal, tangent, uv)
//   csr channel: register writes, csr_ready is always high; write only idle
// pipeline: 17 divider cells, CORDIC_STAGES cordic cells and 4 post stages
//   lie between accept and rsp_valid
// throughput: one transaction per cycle while the pipeline is not stalled;
//   each stage is one cell of each divider or cordic chain, or a post stage
// stall: the whole pipeline holds while rsp_valid is high and rsp_stall
//   is high; req_stall is raised in that cycle only
// reset: empties the pipeline and loads center 0, radius 256,
//   16 rings and 32 slices
module uv_sphere_vertex_generator_unit #(
   parameter int INDEX_BITS    = 10,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [INDEX_BITS-1:0]        req_ring_index,
   input  logic [INDEX_BITS-1:0]        req_slice_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [15:0]           rsp_pos_x,
   output logic signed [15:0]           rsp_pos_y,
   output logic signed [15:0]           rsp_pos_z,
   output logic signed [15:0]           rsp_norm_x,
   output logic signed [15:0]           rsp_norm_y,
   output logic signed [15:0]           rsp_norm_z,
   output logic signed [15:0]           rsp_tan_x,
   output logic signed [15:0]           rsp_tan_y,
   output logic signed [15:0]           rsp_tan_z,
   output logic [16:0]                  rsp_tex_u,
   output logic [16:0]                  rsp_tex_v,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [usvg_pkg::CSR_BITS-1:0] csr_index,
   input  logic [15:0]                  csr_data
);
   import usvg_pkg::*;

   localparam int Latency = QUO_BITS + CORDIC_STAGES + POST_STAGES;

   logic signed [15:0]    center_x_ff, center_y_ff, center_z_ff;
   logic [14:0]           radius_ff;
   logic [COUNT_BITS-1:0] ring_count_ff, slice_count_ff;
   logic [Latency-1:0]    valid_ff;
   logic                  enable;

   logic [INDEX_BITS+COUNT_BITS-1:0] ring_wide, slice_wide;
   logic [INDEX_BITS-1:0] ring_cnt, slice_cnt, ring_idx, slice_idx;
   logic [INDEX_BITS+16:0] ring_num, slice_num;

   logic [INDEX_BITS-1:0] rr_rem [0:QUO_BITS];
   logic [QUO_BITS-1:0]   rr_num [0:QUO_BITS];
   logic [QUO_BITS-1:0]   rr_quo [0:QUO_BITS];
   logic [INDEX_BITS-1:0] sr_rem [0:QUO_BITS];
   logic [QUO_BITS-1:0]   sr_num [0:QUO_BITS];
   logic [QUO_BITS-1:0]   sr_quo [0:QUO_BITS];

   cordic_type  th [0:CORDIC_STAGES];
   cordic_type  ph [0:CORDIC_STAGES];
   logic [16:0] u_pipe_ff [0:CORDIC_STAGES-1];
   logic [16:0] v_pipe_ff [0:CORDIC_STAGES-1];
   logic [31:0] theta_ang, phi_ang;

   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;
   assign csr_ready = 1'b1;
   assign rsp_valid = valid_ff[Latency-1];
   assign rsp_tan_y = 16'sd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         center_z_ff    <= '0;
         radius_ff      <= 15'd256;
         ring_count_ff  <= 10'd16;
         slice_count_ff <= 10'd32;
      end else begin
         if (enable) begin
            valid_ff <= {valid_ff[Latency-2:0], req_valid};
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_CENTER_X:    center_x_ff    <= csr_data;
               CSR_CENTER_Y:    center_y_ff    <= csr_data;
               CSR_CENTER_Z:    center_z_ff    <= csr_data;
               CSR_RADIUS:      radius_ff      <= csr_data[14:0];
               CSR_RING_COUNT:  ring_count_ff  <= csr_data[COUNT_BITS-1:0];
               CSR_SLICE_COUNT: slice_count_ff <= csr_data[COUNT_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      ring_wide  = {{INDEX_BITS{1'b0}}, ring_count_ff};
      slice_wide = {{INDEX_BITS{1'b0}}, slice_count_ff};
      ring_cnt   = ring_wide[INDEX_BITS-1:0];
      slice_cnt  = slice_wide[INDEX_BITS-1:0];
      if (ring_cnt == '0) begin
         ring_cnt = INDEX_BITS'(1);
      end
      if (slice_cnt == '0) begin
         slice_cnt = INDEX_BITS'(1);
      end
      ring_idx  = (req_ring_index > ring_cnt) ? ring_cnt : req_ring_index;
      slice_idx = (req_slice_index > slice_cnt) ? slice_cnt : req_slice_index;
      ring_num  = {ring_idx, 17'd0} >> 1;
      ring_num  = ring_num + (INDEX_BITS+17)'(ring_cnt >> 1);
      slice_num = {slice_idx, 17'd0} >> 1;
      slice_num = slice_num + (INDEX_BITS+17)'(slice_cnt >> 1);
      rr_rem[0] = ring_num[INDEX_BITS+16:QUO_BITS];
      rr_num[0] = ring_num[QUO_BITS-1:0];
      rr_quo[0] = '0;
      sr_rem[0] = slice_num[INDEX_BITS+16:QUO_BITS];
      sr_num[0] = slice_num[QUO_BITS-1:0];
      sr_quo[0] = '0;
   end

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
      usvg_div_cell #(.IndexBits(INDEX_BITS)) u_ring (
         .clock(clock), .enable(enable), .cnt(ring_cnt),
         .rem_in(rr_rem[k]), .num_in(rr_num[k]), .quo_in(rr_quo[k]),
         .rem_out(rr_rem[k+1]), .num_out(rr_num[k+1]), .quo_out(rr_quo[k+1])
      );
      usvg_div_cell #(.IndexBits(INDEX_BITS)) u_slice (
         .clock(clock), .enable(enable), .cnt(slice_cnt),
         .rem_in(sr_rem[k]), .num_in(sr_num[k]), .quo_in(sr_quo[k]),
         .rem_out(sr_rem[k+1]), .num_out(sr_num[k+1]), .quo_out(sr_quo[k+1])
      );
   end

   always_comb begin
      theta_ang = {rr_quo[QUO_BITS][16:0], 15'd0};
      phi_ang   = {sr_quo[QUO_BITS][15:0], 16'd0};
      th[0].flip = theta_ang[31] ^ theta_ang[30];
      th[0].x    = CORDIC_X0;
      th[0].y    = '0;
      th[0].z    = 34'($signed({theta_ang[31] ^ th[0].flip, theta_ang[30:0]}));
      ph[0].flip = phi_ang[31] ^ phi_ang[30];
      ph[0].x    = CORDIC_X0;
      ph[0].y    = '0;
      ph[0].z    = 34'($signed({phi_ang[31] ^ ph[0].flip, phi_ang[30:0]}));
   end

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
      usvg_cordic_cell #(.Stage(s)) u_theta (
         .clock(clock), .enable(enable), .cell_in(th[s]), .cell_out(th[s+1])
      );
      usvg_cordic_cell #(.Stage(s)) u_phi (
         .clock(clock), .enable(enable), .cell_in(ph[s]), .cell_out(ph[s+1])
      );
      always_ff @(posedge clock) begin
         if (enable) begin
            if (s == 0) begin
               u_pipe_ff[s] <= sr_quo[QUO_BITS];
               v_pipe_ff[s] <= rr_quo[QUO_BITS];
            end else begin
               u_pipe_ff[s] <= u_pipe_ff[(s == 0) ? 0 : s-1];
               v_pipe_ff[s] <= v_pipe_ff[(s == 0) ? 0 : s-1];
            end
         end
      end
   end

   usvg_post u_post (
      .clock(clock), .enable(enable),
      .theta(th[CORDIC_STAGES]), .phi(ph[CORDIC_STAGES]),
      .u_in(u_pipe_ff[CORDIC_STAGES-1]), .v_in(v_pipe_ff[CORDIC_STAGES-1]),
      .center_x(center_x_ff), .center_y(center_y_ff), .center_z(center_z_ff),
      .radius(radius_ff),
      .pos_x(rsp_pos_x), .pos_y(rsp_pos_y), .pos_z(rsp_pos_z),
      .norm_x(rsp_norm_x), .norm_y(rsp_norm_y), .norm_z(rsp_norm_z),
      .tan_x(rsp_tan_x), .tan_z(rsp_tan_z),
      .tex_u(rsp_tex_u), .tex_v(rsp_tex_v)
   );

`ifndef NO_ASSERTIONS
   a_hold_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while output is held");
   a_uv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tex_u <= 17'd65536 && rsp_tex_v <= 17'd65536))
      else $error("texture coordinate above one");
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_norm_x <= 16'sd16384 && rsp_norm_x >= -16'sd16384 &&
                     rsp_norm_z <= 16'sd16384 && rsp_norm_z >= -16'sd16384))
      else $error("normal component out of range");
`endif
endmodule

### design/usvg_div_cell.sv
// one restoring division step with its registered remainder, dividend and quotient bits
module usvg_div_cell #(
   parameter int IndexBits = 10
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [IndexBits-1:0]        cnt,
   input  logic [IndexBits-1:0]        rem_in,
   input  logic [usvg_pkg::QUO_BITS-1:0] num_in,
   input  logic [usvg_pkg::QUO_BITS-1:0] quo_in,
   output logic [IndexBits-1:0]        rem_out,
   output logic [usvg_pkg::QUO_BITS-1:0] num_out,
   output logic [usvg_pkg::QUO_BITS-1:0] quo_out
);
   import usvg_pkg::*;

   logic [IndexBits:0]   trial;
   logic                 ge;
   logic [IndexBits:0]   diff;
   logic [IndexBits-1:0] rem_in_next;
   logic [IndexBits-1:0] rem_ff;
   logic [QUO_BITS-1:0]  num_ff;
   logic [QUO_BITS-1:0]  quo_ff;

   always_comb begin
      trial       = {rem_in, num_in[QUO_BITS-1]};
      ge          = trial >= {1'b0, cnt};
      diff        = trial - {1'b0, cnt};
      rem_in_next = ge ? diff[IndexBits-1:0] : trial[IndexBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in_next;
         num_ff <= {num_in[QUO_BITS-2:0], 1'b0};
         quo_ff <= {quo_in[QUO_BITS-2:0], ge};
      end
   end

   assign rem_out = rem_ff;
   assign num_out = num_ff;
   assign quo_out = quo_ff;
endmodule

### design/usvg_cordic_cell.sv
// one registered rotation-mode cordic micro-rotation
module usvg_cordic_cell #(
   parameter int Stage = 0
) (
   input  logic                   clock,
   input  logic                   enable,
   input  usvg_pkg::cordic_type   cell_in,
   output usvg_pkg::cordic_type   cell_out
);
   import usvg_pkg::*;

   cordic_type         cell_ff;
   cordic_type         cell_in_next;
   logic signed [33:0] dx;
   logic signed [33:0] dy;

   always_comb begin
      dx = cell_in.y >>> Stage;
      dy = cell_in.x >>> Stage;
      cell_in_next.flip = cell_in.flip;
      if (cell_in.z >= 0) begin
         cell_in_next.x = cell_in.x - dx;
         cell_in_next.y = cell_in.y + dy;
         cell_in_next.z = cell_in.z - atan_turns(Stage);
      end else begin
         cell_in_next.x = cell_in.x + dx;
         cell_in_next.y = cell_in.y - dy;
         cell_in_next.z = cell_in.z + atan_turns(Stage);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;
endmodule

### design/usvg_post.sv
// products, tangent selection and position stages after the cordic chains
module usvg_post (
   input  logic                      clock,
   input  logic                      enable,
   input  usvg_pkg::cordic_type      theta,
   input  usvg_pkg::cordic_type      phi,
   input  logic [16:0]               u_in,
   input  logic [16:0]               v_in,
   input  logic signed [15:0]        center_x,
   input  logic signed [15:0]        center_y,
   input  logic signed [15:0]        center_z,
   input  logic [14:0]               radius,
   output logic signed [15:0]        pos_x,
   output logic signed [15:0]        pos_y,
   output logic signed [15:0]        pos_z,
   output logic signed [15:0]        norm_x,
   output logic signed [15:0]        norm_y,
   output logic signed [15:0]        norm_z,
   output logic signed [15:0]        tan_x,
   output logic signed [15:0]        tan_z,
   output logic [16:0]               tex_u,
   output logic [16:0]               tex_v
);
   import usvg_pkg::*;

   logic signed [33:0] st_full;
   logic signed [33:0] sp_full;
   logic signed [33:0] cp_full;
   logic signed [33:0] ct_full;

   logic signed [31:0] st1_ff, sp1_ff, cp1_ff;
   logic signed [15:0] st14_1_ff, sp14_1_ff, cp14_1_ff, ny1_ff;
   logic [16:0]        u1_ff, v1_ff;

   logic signed [63:0] pc2_ff, ps2_ff;
   logic signed [15:0] st14_2_ff, sp14_2_ff, cp14_2_ff, ny2_ff;
   logic [16:0]        u2_ff, v2_ff;

   logic signed [63:0] rc3, rs3;
   logic signed [15:0] nx3_in, nz3_in, tx3_in, tz3_in;
   logic signed [15:0] nx3_ff, ny3_ff, nz3_ff, tx3_ff, tz3_ff;
   logic [16:0]        u3_ff, v3_ff;

   logic signed [15:0] px4_in, py4_in, pz4_in;
   logic signed [15:0] px4_ff, py4_ff, pz4_ff;
   logic signed [15:0] nx4_ff, ny4_ff, nz4_ff, tx4_ff, tz4_ff;
   logic [16:0]        u4_ff, v4_ff;

   function automatic logic signed [15:0] clamp_q14(input logic signed [63:0] v);
      if (v > 64'sd16384) begin
         return ONE_Q14;
      end else if (v < -64'sd16384) begin
         return -ONE_Q14;
      end else begin
         return v[15:0];
      end
   endfunction

   function automatic logic signed [15:0] place(input logic signed [15:0] c,
                                               input logic [14:0] r,
                                               input logic signed [15:0] n);
      logic signed [31:0] prod;
      logic signed [31:0] sum;
      prod = $signed({1'b0, r}) * n;
      sum  = 32'(c) + ((prod + 32'sd8192) >>> 14);
      if (sum > 32'sd32767) begin
         return 16'sh7fff;
      end else if (sum < -32'sd32768) begin
         return 16'sh8000;
      end else begin
         return sum[15:0];
      end
   endfunction

   always_comb begin
      st_full = theta.flip ? -theta.y : theta.y;
      ct_full = theta.flip ? -theta.x : theta.x;
      sp_full = phi.flip ? -phi.y : phi.y;
      cp_full = phi.flip ? -phi.x : phi.x;
   end

   always_comb begin
      rc3    = (pc2_ff + 64'sh2000_0000_0000) >>> 46;
      rs3    = (ps2_ff + 64'sh2000_0000_0000) >>> 46;
      nx3_in = clamp_q14(rc3);
      nz3_in = clamp_q14(rs3);
      if (st14_2_ff < 16'sd1) begin
         tx3_in = ONE_Q14;
         tz3_in = 16'sd0;
      end else begin
         tx3_in = -sp14_2_ff;
         tz3_in = cp14_2_ff;
      end
   end

   always_comb begin
      px4_in = place(center_x, radius, nx3_ff);
      py4_in = place(center_y, radius, ny3_ff);
      pz4_in = place(center_z, radius, nz3_ff);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         st1_ff    <= st_full[31:0];
         sp1_ff    <= sp_full[31:0];
         cp1_ff    <= cp_full[31:0];
         st14_1_ff <= to_q14(st_full);
         sp14_1_ff <= to_q14(sp_full);
         cp14_1_ff <= to_q14(cp_full);
         ny1_ff    <= to_q14(ct_full);
         u1_ff     <= u_in;
         v1_ff     <= v_in;

         pc2_ff    <= 64'(st1_ff) * 64'(cp1_ff);
         ps2_ff    <= 64'(st1_ff) * 64'(sp1_ff);
         st14_2_ff <= st14_1_ff;
         sp14_2_ff <= sp14_1_ff;
         cp14_2_ff <= cp14_1_ff;
         ny2_ff    <= ny1_ff;
         u2_ff     <= u1_ff;
         v2_ff     <= v1_ff;

         nx3_ff <= nx3_in;
         ny3_ff <= ny2_ff;
         nz3_ff <= nz3_in;
         tx3_ff <= tx3_in;
         tz3_ff <= tz3_in;
         u3_ff  <= u2_ff;
         v3_ff  <= v2_ff;

         px4_ff <= px4_in;
         py4_ff <= py4_in;
         pz4_ff <= pz4_in;
         nx4_ff <= nx3_ff;
         ny4_ff <= ny3_ff;
         nz4_ff <= nz3_ff;
         tx4_ff <= tx3_ff;
         tz4_ff <= tz3_ff;
         u4_ff  <= u3_ff;
         v4_ff  <= v3_ff;
      end
   end

   assign pos_x  = px4_ff;
   assign pos_y  = py4_ff;
   assign pos_z  = pz4_ff;
   assign norm_x = nx4_ff;
   assign norm_y = ny4_ff;
   assign norm_z = nz4_ff;
   assign tan_x  = tx4_ff;
   assign tan_z  = tz4_ff;
   assign tex_u  = u4_ff;
   assign tex_v  = v4_ff;
endmodule
